FILE: src/rps_pkg.sv
`default_nettype none
package rps_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int COORD_W    = 16;
    localparam int PT_W       = 3 * COORD_W;
    localparam int D_W        = COORD_W + 1;
    localparam int XP_W       = 2 * D_W;
    localparam int N_W        = XP_W + 1;
    localparam int SQ_W       = 2 * N_W;
    localparam int ACC_W      = SQ_W + 2;
    localparam int ACC_H      = ACC_W / 2;
    localparam int TOL_W      = 15;
    localparam int TOL2_W     = 2 * TOL_W;
    localparam int PR_W       = N_W + D_W;
    localparam int DOT_W      = PR_W + 2;
    localparam int M_W        = DOT_W;
    localparam int MH_W       = M_W / 2;
    localparam int M2_W       = 2 * M_W;
    localparam int TOL_RESET  = 51;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TRIAL = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef struct packed {
        logic       take;
        logic [1:0] rd_sel;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic       calc_uv;
        logic       calc_xp;
        logic       calc_n;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       bnd_lo;
        logic       bnd_hi;
        logic       sweep_start;
        logic       finish;
        logic       q_cap;
        logic       out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] chk;
        logic       sweep_done;
    } t_dp_stat;
endpackage
`default_nettype wire

FILE: src/ransac_plane_segmenter.sv
// Clear, load and failed commands go straight to the output state; a query
// first reads the best-set mask; a trial does plane setup, then one stored point
// per cycle through the distance pipeline, limited by the point memory port.
// Throughput: one item at a time; the next item is taken once the result
// register is free or being drained.
// Reset (i_rst_n low, synchronous): cloud empty, best count zero, tolerance 51.
`default_nettype none
module ransac_plane_segmenter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x[15:0] y[31:16] z[47:32] sample_a[59:48] sample_b[71:60]
    // sample_c[83:72] query_index[95:84]
    input  wire logic [95:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // trial_inliers[12:0] became_best[13] best_inliers[26:14]
    // points_loaded[39:27] is_plane[40], zero fill
    output logic [47:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]       m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [14:0] i_cfg_data
);
    import rps_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    rps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rps_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tdata  (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );
endmodule
`default_nettype wire

FILE: src/rps_ram.sv
`default_nettype none
module rps_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/rps_ctrl.sv
`default_nettype none
module rps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire rps_pkg::t_dp_stat i_stat,
    output rps_pkg::t_dp_cmd       o_cmd
);
    import rps_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RDA  = 5'd1;
    localparam logic [4:0] S_RDB  = 5'd2;
    localparam logic [4:0] S_RDC  = 5'd3;
    localparam logic [4:0] S_CAP  = 5'd4;
    localparam logic [4:0] S_UV   = 5'd5;
    localparam logic [4:0] S_XP   = 5'd6;
    localparam logic [4:0] S_N    = 5'd7;
    localparam logic [4:0] S_SQ0  = 5'd8;
    localparam logic [4:0] S_SQ1  = 5'd9;
    localparam logic [4:0] S_SQ2  = 5'd10;
    localparam logic [4:0] S_B0   = 5'd11;
    localparam logic [4:0] S_B1   = 5'd12;
    localparam logic [4:0] S_SWP  = 5'd13;
    localparam logic [4:0] S_FIN  = 5'd14;
    localparam logic [4:0] S_QRD  = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_free;

    assign w_free     = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_free;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_cmd.rd_sel = SEL_A;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && w_free) begin
                    o_cmd.take = 1'b1;
                    n_state = S_OUT;
                    if (i_stat.chk == ST_OK) begin
                        if (i_stat.cmd == CMD_TRIAL) begin
                            n_state = S_RDA;
                        end else if (i_stat.cmd == CMD_QUERY) begin
                            n_state = S_QRD;
                        end
                    end
                end
            end
            S_RDA: begin
                o_cmd.rd_sel = SEL_A;
                n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_sel = SEL_B;
                o_cmd.cap_a  = 1'b1;
                n_state = S_RDC;
            end
            S_RDC: begin
                o_cmd.rd_sel = SEL_C;
                o_cmd.cap_b  = 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_c = 1'b1;
                n_state = S_UV;
            end
            S_UV: begin
                o_cmd.calc_uv = 1'b1;
                n_state = S_XP;
            end
            S_XP: begin
                o_cmd.calc_xp = 1'b1;
                n_state = S_N;
            end
            S_N: begin
                o_cmd.calc_n = 1'b1;
                n_state = S_SQ0;
            end
            S_SQ0: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = 2'd0;
                n_state = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = 2'd1;
                n_state = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = 2'd2;
                n_state = S_B0;
            end
            S_B0: begin
                o_cmd.bnd_lo = 1'b1;
                n_state = S_B1;
            end
            S_B1: begin
                o_cmd.bnd_hi      = 1'b1;
                o_cmd.sweep_start = 1'b1;
                n_state = S_SWP;
            end
            S_SWP: begin
                if (i_stat.sweep_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_QRD: begin
                o_cmd.q_cap = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // slot is free here: it was free when the item was taken
                o_cmd.out_ld = 1'b1;
                n_out_valid  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

FILE: src/rps_dp.sv
`default_nettype none
module rps_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [1:0]                 i_s_tuser,
    input  wire logic [95:0]                i_s_tdata,
    input  wire logic                       i_cfg_we,
    input  wire logic [rps_pkg::TOL_W-1:0]  i_cfg_data,
    input  wire rps_pkg::t_dp_cmd           i_cmd,
    output rps_pkg::t_dp_stat               o_stat,
    output logic [47:0]                     o_m_tdata,
    output logic [1:0]                      o_m_tuser
);
    import rps_pkg::*;

    // input fields
    logic [PT_W-1:0]  w_in_pt;
    logic [IDX_W-1:0] w_in_a, w_in_b, w_in_c, w_in_q;
    assign w_in_pt = i_s_tdata[PT_W-1:0];
    assign w_in_a  = i_s_tdata[59:48];
    assign w_in_b  = i_s_tdata[71:60];
    assign w_in_c  = i_s_tdata[83:72];
    assign w_in_q  = i_s_tdata[95:84];

    logic [CNT_W-1:0] r_pc, r_best, r_trial_n;
    logic             r_bank;
    logic [TOL_W-1:0] r_tol;
    logic [1:0]       r_status, r_cmd;
    logic             r_became, r_label;
    logic [IDX_W-1:0] r_a, r_b, r_c;

    // checks on the item offered at the input
    logic [1:0] w_chk;
    always_comb begin
        w_chk = ST_OK;
        case (i_s_tuser)
            CMD_CLEAR: w_chk = ST_OK;
            CMD_LOAD: begin
                if (r_pc == CNT_W'(MAX_POINTS)) w_chk = ST_FULL;
            end
            CMD_TRIAL: begin
                if (r_pc == '0) w_chk = ST_EMPTY;
                else if ({1'b0, w_in_a} >= r_pc || {1'b0, w_in_b} >= r_pc
                         || {1'b0, w_in_c} >= r_pc) w_chk = ST_RANGE;
            end
            CMD_QUERY: begin
                if (r_pc == '0) w_chk = ST_EMPTY;
                else if ({1'b0, w_in_q} >= r_pc) w_chk = ST_RANGE;
            end
            default: w_chk = ST_OK;
        endcase
    end

    logic w_load;
    assign w_load = i_cmd.take && (i_s_tuser == CMD_LOAD) && (w_chk == ST_OK);

    // point store
    logic [IDX_W-1:0] w_praddr;
    logic [PT_W-1:0]  w_prdata;
    logic             r_issuing;
    logic [CNT_W-1:0] r_idx;

    always_comb begin
        case (i_cmd.rd_sel)
            SEL_A:   w_praddr = r_a;
            SEL_B:   w_praddr = r_b;
            SEL_C:   w_praddr = r_c;
            default: w_praddr = r_a;
        endcase
        if (r_issuing) w_praddr = r_idx[IDX_W-1:0];
    end

    rps_ram #(.W(PT_W), .D(MAX_POINTS)) u_pts (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_pc[IDX_W-1:0]),
        .i_wdata (w_in_pt),
        .i_raddr (w_praddr),
        .o_rdata (w_prdata)
    );

    // mask banks: best set lives in bank r_bank, a trial writes the other one
    logic             v6;
    logic [IDX_W-1:0] i6;
    logic             w_in_plane;
    logic [1:0]       w_mwe;
    logic [IDX_W-1:0] w_mwaddr;
    logic             w_mwdata;
    logic [1:0]       w_mrdata;

    always_comb begin
        w_mwe    = 2'b00;
        w_mwaddr = r_pc[IDX_W-1:0];
        w_mwdata = 1'b0;
        if (w_load) begin
            w_mwe = 2'b11;
        end else if (v6) begin
            w_mwe    = r_bank ? 2'b01 : 2'b10;
            w_mwaddr = i6;
            w_mwdata = w_in_plane;
        end
    end

    rps_ram #(.W(1), .D(MAX_POINTS)) u_mask0 (
        .i_clk   (i_clk),
        .i_we    (w_mwe[0]),
        .i_waddr (w_mwaddr),
        .i_wdata (w_mwdata),
        .i_raddr (w_in_q),
        .o_rdata (w_mrdata[0])
    );

    rps_ram #(.W(1), .D(MAX_POINTS)) u_mask1 (
        .i_clk   (i_clk),
        .i_we    (w_mwe[1]),
        .i_waddr (w_mwaddr),
        .i_wdata (w_mwdata),
        .i_raddr (w_in_q),
        .o_rdata (w_mrdata[1])
    );

    // plane setup
    logic signed [COORD_W-1:0] r_pa [3];
    logic signed [COORD_W-1:0] r_pb [3];
    logic signed [COORD_W-1:0] r_pc3 [3];
    logic signed [D_W-1:0]     r_u [3];
    logic signed [D_W-1:0]     r_v [3];
    logic signed [XP_W-1:0]    r_xp [6];
    logic signed [N_W-1:0]     r_n [3];
    logic [TOL2_W-1:0]         r_tol2;
    logic [ACC_W-1:0]          r_acc;
    logic [M2_W-1:0]           r_bnd;
    logic signed [N_W-1:0]     w_nsel;
    logic [N_W-1:0]            w_nmag;
    logic signed [COORD_W-1:0] w_rd [3];

    assign w_rd[0] = w_prdata[COORD_W-1:0];
    assign w_rd[1] = w_prdata[2*COORD_W-1:COORD_W];
    assign w_rd[2] = w_prdata[3*COORD_W-1:2*COORD_W];

    always_comb begin
        case (i_cmd.sq_sel)
            2'd0:    w_nsel = r_n[0];
            2'd1:    w_nsel = r_n[1];
            2'd2:    w_nsel = r_n[2];
            default: w_nsel = r_n[0];
        endcase
        w_nmag = w_nsel[N_W-1] ? N_W'(-w_nsel) : N_W'(w_nsel);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.cap_a) r_pa[k] <= w_rd[k];
            if (i_cmd.cap_b) r_pb[k] <= w_rd[k];
            if (i_cmd.cap_c) r_pc3[k] <= w_rd[k];
            if (i_cmd.calc_uv) begin
                r_u[k] <= {r_pb[k][COORD_W-1], r_pb[k]} - {r_pa[k][COORD_W-1], r_pa[k]};
                r_v[k] <= {r_pc3[k][COORD_W-1], r_pc3[k]} - {r_pa[k][COORD_W-1], r_pa[k]};
            end
        end
        if (i_cmd.calc_uv) r_tol2 <= TOL2_W'(r_tol) * TOL2_W'(r_tol);
        if (i_cmd.calc_xp) begin
            r_xp[0] <= XP_W'(r_u[1] * r_v[2]);
            r_xp[1] <= XP_W'(r_u[2] * r_v[1]);
            r_xp[2] <= XP_W'(r_u[2] * r_v[0]);
            r_xp[3] <= XP_W'(r_u[0] * r_v[2]);
            r_xp[4] <= XP_W'(r_u[0] * r_v[1]);
            r_xp[5] <= XP_W'(r_u[1] * r_v[0]);
        end
        if (i_cmd.calc_n) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= {r_xp[2*k][XP_W-1], r_xp[2*k]}
                        - {r_xp[2*k+1][XP_W-1], r_xp[2*k+1]};
            end
            r_acc <= '0;
        end
        if (i_cmd.sq_en) r_acc <= r_acc + ACC_W'(SQ_W'(w_nmag) * SQ_W'(w_nmag));
        if (i_cmd.bnd_lo) r_bnd <= M2_W'(M2_W'(r_acc[ACC_H-1:0]) * M2_W'(r_tol2));
        if (i_cmd.bnd_hi) begin
            r_bnd <= r_bnd + (M2_W'(M2_W'(r_acc[ACC_W-1:ACC_H]) * M2_W'(r_tol2)) << ACC_H);
        end
    end

    // sweep pipeline: read, offset, products, dot, magnitude, partials, square
    logic                     v0, v1, v2, v3, v4, v5;
    logic [IDX_W-1:0]         i0, i1, i2, i3, i4, i5;
    logic signed [D_W-1:0]    r_d [3];
    logic signed [PR_W-1:0]   r_pr [3];
    logic signed [DOT_W-1:0]  r_dot;
    logic [M_W-1:0]           r_m;
    logic [2*MH_W-1:0]        r_hh, r_hl, r_ll;
    logic [M2_W-1:0]          r_m2;

    assign w_in_plane = r_m2 < r_bnd;

    always_ff @(posedge i_clk) begin
        i0 <= r_idx[IDX_W-1:0];
        i1 <= i0; i2 <= i1; i3 <= i2; i4 <= i3; i5 <= i4; i6 <= i5;
        for (int k = 0; k < 3; k++) begin
            r_d[k]  <= {w_rd[k][COORD_W-1], w_rd[k]} - {r_pa[k][COORD_W-1], r_pa[k]};
            r_pr[k] <= PR_W'(r_n[k] * r_d[k]);
        end
        r_dot <= DOT_W'(r_pr[0]) + DOT_W'(r_pr[1]) + DOT_W'(r_pr[2]);
        r_m   <= r_dot[DOT_W-1] ? M_W'(-r_dot) : M_W'(r_dot);
        r_hh  <= (2*MH_W)'(r_m[M_W-1:MH_W]) * (2*MH_W)'(r_m[M_W-1:MH_W]);
        r_hl  <= (2*MH_W)'(r_m[M_W-1:MH_W]) * (2*MH_W)'(r_m[MH_W-1:0]);
        r_ll  <= (2*MH_W)'(r_m[MH_W-1:0]) * (2*MH_W)'(r_m[MH_W-1:0]);
        r_m2  <= (M2_W'(r_hh) << (2*MH_W)) + (M2_W'(r_hl) << (MH_W + 1)) + M2_W'(r_ll);
    end

    assign o_stat.cmd        = i_s_tuser;
    assign o_stat.chk        = w_chk;
    assign o_stat.sweep_done = !r_issuing && !i_cmd.sweep_start
                               && !(v0 || v1 || v2 || v3 || v4 || v5 || v6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_best    <= '0;
            r_bank    <= 1'b0;
            r_tol     <= TOL_W'(TOL_RESET);
            r_issuing <= 1'b0;
            {v0, v1, v2, v3, v4, v5, v6} <= '0;
        end else begin
            if (i_cfg_we) r_tol <= i_cfg_data;
            if (i_cmd.take && i_s_tuser == CMD_CLEAR) begin
                r_pc   <= '0;
                r_best <= '0;
            end
            if (w_load) r_pc <= r_pc + 1'b1;
            if (i_cmd.sweep_start) begin
                r_issuing <= 1'b1;
                r_idx     <= '0;
            end else if (r_issuing) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx + 1'b1 == r_pc) r_issuing <= 1'b0;
            end
            v0 <= r_issuing;
            {v1, v2, v3, v4, v5, v6} <= {v0, v1, v2, v3, v4, v5};
            if (i_cmd.finish && r_trial_n > r_best) begin
                r_best <= r_trial_n;
                r_bank <= !r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cmd     <= i_s_tuser;
            r_status  <= w_chk;
            r_a       <= w_in_a;
            r_b       <= w_in_b;
            r_c       <= w_in_c;
            r_trial_n <= '0;
            r_became  <= 1'b0;
            r_label   <= 1'b0;
        end
        if (v6 && w_in_plane) r_trial_n <= r_trial_n + 1'b1;
        if (i_cmd.finish) r_became <= r_trial_n > r_best;
        if (i_cmd.q_cap) r_label <= w_mrdata[r_bank];
        if (i_cmd.out_ld) begin
            o_m_tuser <= r_status;
            o_m_tdata <= {7'd0, r_label, r_pc, r_best, r_became,
                          (r_cmd == CMD_TRIAL) ? r_trial_n : CNT_W'(0)};
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
    import rps_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] trial;
        logic        became;
        logic [12:0] best;
        logic [12:0] loaded;
        logic        plane;
    } t_seg_res;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] x, y, z;
        logic [11:0] a, b, c, q;
        logic        typed;
        t_seg_res    res;
    } t_stim_row;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data;

    ransac_plane_segmenter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the segmenter state
    logic signed [15:0] cloud_x [MAX_POINTS];
    logic signed [15:0] cloud_y [MAX_POINTS];
    logic signed [15:0] cloud_z [MAX_POINTS];
    bit                 best_lbl [MAX_POINTS];
    bit                 trial_lbl [MAX_POINTS];
    int unsigned        n_points;
    int unsigned        n_best;
    logic [14:0]        tol;

    t_seg_res    pending_res[$];
    int          errs;
    int          items_sent;
    int          results_seen;
    int          trials_run;
    int          send_pct;
    int          recv_pct;
    longint      cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ransac_plane_segmenter regression: fail");
            $finish;
        end
    end

    function automatic logic [127:0] sq_mag(longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return {64'b0, m} * {64'b0, m};
    endfunction

    function automatic t_seg_res predict_segment(logic [1:0] cmd, logic [15:0] x, y, z,
                                                 logic [11:0] a, b, c, q);
        t_seg_res r;
        longint ux, uy, uz, vx, vy, vz, nx, ny, nz, dot;
        logic [127:0] bound;
        int unsigned hits;
        r = '0;
        hits = 0;
        case (cmd)
            CMD_CLEAR: begin
                n_points = 0;
                n_best = 0;
                for (int i = 0; i < MAX_POINTS; i++) best_lbl[i] = 0;
            end
            CMD_LOAD: begin
                if (n_points >= MAX_POINTS) r.status = ST_FULL;
                else begin
                    cloud_x[n_points] = x;
                    cloud_y[n_points] = y;
                    cloud_z[n_points] = z;
                    best_lbl[n_points] = 0;
                    n_points++;
                end
            end
            CMD_TRIAL: begin
                if (n_points == 0) r.status = ST_EMPTY;
                else if (a >= n_points || b >= n_points || c >= n_points) r.status = ST_RANGE;
                else begin
                    ux = longint'(cloud_x[b]) - longint'(cloud_x[a]);
                    uy = longint'(cloud_y[b]) - longint'(cloud_y[a]);
                    uz = longint'(cloud_z[b]) - longint'(cloud_z[a]);
                    vx = longint'(cloud_x[c]) - longint'(cloud_x[a]);
                    vy = longint'(cloud_y[c]) - longint'(cloud_y[a]);
                    vz = longint'(cloud_z[c]) - longint'(cloud_z[a]);
                    nx = uy * vz - uz * vy;
                    ny = uz * vx - ux * vz;
                    nz = ux * vy - uy * vx;
                    bound = (sq_mag(nx) + sq_mag(ny) + sq_mag(nz))
                            * ({113'b0, tol} * {113'b0, tol});
                    for (int i = 0; i < n_points; i++) begin
                        dot = nx * (longint'(cloud_x[i]) - longint'(cloud_x[a]))
                            + ny * (longint'(cloud_y[i]) - longint'(cloud_y[a]))
                            + nz * (longint'(cloud_z[i]) - longint'(cloud_z[a]));
                        trial_lbl[i] = sq_mag(dot) < bound;
                        if (trial_lbl[i]) hits++;
                    end
                    r.trial = hits[12:0];
                    if (hits > n_best) begin
                        n_best = hits;
                        for (int i = 0; i < MAX_POINTS; i++)
                            best_lbl[i] = (i < n_points) ? trial_lbl[i] : 0;
                        r.became = 1'b1;
                    end
                end
            end
            default: begin
                if (n_points == 0) r.status = ST_EMPTY;
                else if (q >= n_points) r.status = ST_RANGE;
                else r.plane = best_lbl[q];
            end
        endcase
        r.best = n_best[12:0];
        r.loaded = n_points[12:0];
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [15:0] x, y, z,
                             logic [11:0] a, b, c, q, bit typed, t_seg_res tres);
        t_seg_res p;
        while ($urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q, c, b, a, z, y, x};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_segment(cmd, x, y, z, a, b, c, q);
        pending_res.insert(pending_res.size(), typed ? tres : p);
        items_sent++;
        if (cmd == CMD_TRIAL) trials_run++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_tol(logic [14:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tol = v;
    endtask

    task automatic cmd_only(logic [1:0] cmd, logic [11:0] a, b, c, q);
        send_item(cmd, 16'($urandom), 16'($urandom), 16'($urandom), a, b, c, q, 0, '0);
    endtask

    // ground points near z = 0, a quarter of them raised as obstacles
    task automatic load_ground(bit wild);
        logic [15:0] x, y, z;
        x = 16'($signed($urandom_range(4000)) - 2000);
        y = 16'($signed($urandom_range(4000)) - 2000);
        z = 16'($signed($urandom_range(80)) - 40);
        if ($urandom_range(3) == 0) z = 16'($urandom_range(300, 3000));
        if (wild) begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
        end
        send_item(CMD_LOAD, x, y, z, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 0, '0);
    endtask

    function automatic logic [11:0] pick_idx();
        if ($urandom_range(15) == 0) return 12'($urandom);
        return 12'($urandom_range(n_points == 0 ? 0 : n_points - 1));
    endfunction

    task automatic random_burst(int stop_at);
        int n;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                cmd_only(CMD_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
                n = $urandom_range(3, 12);
                for (int i = 0; i < n; i++) load_ground($urandom_range(9) == 0);
                repeat ($urandom_range(2, 5)) begin
                    cmd_only(CMD_TRIAL, pick_idx(), pick_idx(), pick_idx(), 12'($urandom));
                    cmd_only(CMD_QUERY, 12'($urandom), 12'($urandom), 12'($urandom), pick_idx());
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                              0, '0);
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_seg_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_res.size() == 0) begin
                $error("result with no pending expectation");
                errs++;
            end else begin
                e = pending_res.pop_front();
                if (m_axis_tuser != e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tuser); errs++;
                end
                if (m_axis_tdata[12:0] != e.trial) begin
                    $error("trial_inliers exp %0d got %0d", e.trial, m_axis_tdata[12:0]); errs++;
                end
                if (m_axis_tdata[13] != e.became) begin
                    $error("became_best exp %0d got %0d", e.became, m_axis_tdata[13]); errs++;
                end
                if (m_axis_tdata[26:14] != e.best) begin
                    $error("best_inliers exp %0d got %0d", e.best, m_axis_tdata[26:14]); errs++;
                end
                if (m_axis_tdata[39:27] != e.loaded) begin
                    $error("points_loaded exp %0d got %0d", e.loaded, m_axis_tdata[39:27]);
                    errs++;
                end
                if (m_axis_tdata[40] != e.plane) begin
                    $error("is_plane exp %0d got %0d", e.plane, m_axis_tdata[40]); errs++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end

    t_stim_row dir_rows[$];

    function automatic void queue_row(t_stim_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic t_stim_row row(logic [1:0] cmd, logic [15:0] x, y, z,
                                      logic [11:0] a, b, c, q, bit typed,
                                      logic [1:0] st, int ld);
        t_stim_row r;
        r.cmd = cmd; r.x = x; r.y = y; r.z = z;
        r.a = a; r.b = b; r.c = c; r.q = q;
        r.typed = typed;
        r.res = '0;
        r.res.status = st;
        r.res.loaded = 13'(ld);
        return r;
    endfunction

    initial begin
        cycles = 0; errs = 0; items_sent = 0; results_seen = 0; trials_run = 0;
        n_points = 0; n_best = 0; tol = 15'(TOL_RESET);
        for (int i = 0; i < MAX_POINTS; i++) best_lbl[i] = 0;
        send_pct = 36; recv_pct = 68;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty cloud first, then a small cloud with extreme coordinates, then a clear
        queue_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
        queue_row(row(CMD_LOAD, 0, 0, 0, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
                      1, ST_OK, 1));
        queue_row(row(CMD_LOAD, 256, 0, 0, 0, 0, 0, 0, 1, ST_OK, 2));
        queue_row(row(CMD_LOAD, 0, 256, 0, 0, 0, 0, 0, 1, ST_OK, 3));
        queue_row(row(CMD_LOAD, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0, 0,
                      1, ST_OK, 4));
        queue_row(row(CMD_LOAD, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0, 0,
                      1, ST_OK, 5));
        queue_row(row(CMD_LOAD, 128, 128, 20, 0, 0, 0, 0, 0, ST_OK, 0));
        queue_row(row(CMD_LOAD, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 0,
                      0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 1, 2, 0, 0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 1, 2, 0, 0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 1, 1, 0, 0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 3, 4, 6, 0, 0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 7, 0, 1, 0, 0, ST_OK, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 12'hfff, 1, 0, 0, ST_OK, 0));
        queue_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0));
        queue_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 6, 0, ST_OK, 0));
        queue_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 7, 0, ST_OK, 0));
        queue_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 12'hfff, 0, ST_OK, 0));
        queue_row(row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0));
        queue_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
        queue_row(row(CMD_TRIAL, 0, 0, 0, 0, 1, 2, 0, 1, ST_EMPTY, 0));
        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                      dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].q,
                      dir_rows[i].typed, dir_rows[i].res);

        write_tol(15'h7fff);
        random_burst(items_sent + 22);
        send_pct = 68; recv_pct = 36;
        write_tol(15'd0);
        random_burst(items_sent + 22);
        send_pct = 0; recv_pct = 0;
        write_tol(15'($urandom_range(1, 400)));
        random_burst(items_sent + 22);
        write_tol(15'(TOL_RESET));
        random_burst(items_sent + 22);

        drain();
        $display("covered %0d items, %0d results, %0d trials, tolerance 0/51/max/random,",
                 items_sent, results_seen, trials_run);
        $display("empty and out of range cases, extreme coordinates, three idling mixes");
        if (errs == 0) begin
            $display("ransac_plane_segmenter regression: pass");
        end else begin
            $display("ransac_plane_segmenter regression: fail");
        end
        $finish;
    end
endmodule
